// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the date-to-epoch converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent true implies consequent true in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/idte_pkg.sv =====
// Package with types, constants and tables of the date-to-epoch converter.
`timescale 1ns / 1ps
`default_nettype none

package idte_pkg;

  // Characters recognised by the parser.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Field being read.
  localparam logic [2:0] PH_YEAR   = 3'd0;
  localparam logic [2:0] PH_MONTH  = 3'd1;
  localparam logic [2:0] PH_DAY    = 3'd2;
  localparam logic [2:0] PH_HOUR   = 3'd3;
  localparam logic [2:0] PH_MINUTE = 3'd4;
  localparam logic [2:0] PH_SECOND = 3'd5;

  // Position inside one number.
  localparam logic [1:0] NS_START  = 2'd0;
  localparam logic [1:0] NS_SIGN   = 2'd1;
  localparam logic [1:0] NS_DIGITS = 2'd2;

  // Year bias of 400 * 2^23 keeps the shifted year positive for the era division.
  localparam logic [33:0] YEAR_BIAS  = 34'd3355443200;
  localparam logic [23:0] ERA_OFFSET = 24'd8388608;
  // ceil(2^35 / 25): quotient by 25 of a 29-bit value is (v * RECIP_25) >> 35.
  localparam logic [30:0] RECIP_25   = 31'd1374389535;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    ST_PARSE,
    ST_BIAS,
    ST_DIV,
    ST_REM,
    ST_DOE,
    ST_DAYS,
    ST_PROD,
    ST_SUM
  } idte_state_t;

  typedef struct packed {
    logic take;
    logic bias;
    logic div;
    logic rem;
    logic doe;
    logic days;
    logic prod;
    logic load;
  } idte_cmd_t;

  typedef struct packed {
    logic end_char;
  } idte_status_t;

  // Separator that must follow each of the first five numbers.
  function automatic logic [7:0] sep_char(input logic [2:0] phase);
    logic [7:0] ch;
    case (phase)
      PH_YEAR, PH_MONTH: ch = CH_MINUS;
      PH_DAY:            ch = CH_T;
      default:           ch = CH_COLON;
    endcase
    return ch;
  endfunction

  // Days from the first of March to the first of the given month.
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd3:    days = 9'd0;
      4'd4:    days = 9'd31;
      4'd5:    days = 9'd61;
      4'd6:    days = 9'd92;
      4'd7:    days = 9'd122;
      4'd8:    days = 9'd153;
      4'd9:    days = 9'd184;
      4'd10:   days = 9'd214;
      4'd11:   days = 9'd245;
      4'd12:   days = 9'd275;
      4'd1:    days = 9'd306;
      4'd2:    days = 9'd337;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/idte_char_if.sv =====
// Stream interface that carries one text character per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface idte_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/idte_epoch_if.sv =====
// Stream interface that carries one converted timestamp per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface idte_epoch_if;
  logic               valid;
  logic               ready;
  logic signed [56:0] epoch_seconds;
  logic               parse_ok;

  modport source (output valid, output epoch_seconds, output parse_ok, input ready);
  modport sink (input valid, input epoch_seconds, input parse_ok, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/idte_ctrl.sv =====
// Controller state machine: parsing, the conversion sequence and the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module idte_ctrl
  import idte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         out_ready,
  input  idte_status_t status,
  output logic         in_ready,
  output logic         out_valid,
  output idte_cmd_t    cmd
);

  idte_state_t state;
  idte_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PARSE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_PARSE: begin
        if (in_valid && status.end_char) begin
          state_next = ST_BIAS;
        end
      end
      ST_BIAS: state_next = ST_DIV;
      ST_DIV:  state_next = ST_REM;
      ST_REM:  state_next = ST_DOE;
      ST_DOE:  state_next = ST_DAYS;
      ST_DAYS: state_next = ST_PROD;
      ST_PROD: state_next = ST_SUM;
      ST_SUM: begin
        if (out_free) begin
          state_next = ST_PARSE;
        end
      end
      default: state_next = ST_PARSE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_PARSE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_BIAS: cmd.bias = 1'b1;
      ST_DIV:  cmd.div  = 1'b1;
      ST_REM:  cmd.rem  = 1'b1;
      ST_DOE:  cmd.doe  = 1'b1;
      ST_DAYS: cmd.days = 1'b1;
      ST_PROD: cmd.prod = 1'b1;
      ST_SUM:  cmd.load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/idte_datapath.sv =====
// Datapath: character parser, calendar arithmetic stages and output register.
`timescale 1ns / 1ps
`default_nettype none

module idte_datapath
  import idte_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_byte,
  input  logic               last_char,
  input  idte_cmd_t          cmd,
  output idte_status_t       status,
  output logic signed [56:0] epoch_seconds,
  output logic               parse_ok
);

  // Parser state.
  logic [2:0]         phase, phase_next;
  logic [1:0]         stage, stage_next;
  logic               neg, neg_next;
  logic [29:0]        acc, acc_next;
  logic [3:0]         cnt, cnt_next;
  logic signed [30:0] yr, yr_next;
  logic signed [30:0] mo, mo_next;
  logic signed [30:0] dy, dy_next;
  logic signed [30:0] hr, hr_next;
  logic signed [30:0] mi, mi_next;
  logic signed [30:0] sc, sc_next;
  logic               failed, failed_next;
  logic               done, done_next;

  logic               end_char;
  logic               is_digit;
  logic               is_space;
  logic [3:0]         digit;
  logic signed [30:0] val_cur;
  logic signed [30:0] val_fin;
  logic               ok_next;

  // Conversion stages.
  logic               calc_ok;
  logic [33:0]        ys;
  logic [33:0]        u_sum;
  logic [32:0]        u_r;
  logic [59:0]        prod;
  logic [23:0]        q_r;
  logic [32:0]        qx400;
  logic [8:0]         yoe_r;
  logic signed [23:0] era_r;
  logic [1:0]         cent;
  logic [8:0]         doy;
  logic [17:0]        doe_r;
  logic signed [41:0] em_r;
  logic signed [41:0] days_r;
  logic [36:0]        plo_r;
  logic signed [43:0] hms_r;
  logic signed [39:0] phi;
  logic [59:0]        total;

  assign end_char        = (char_byte == CH_NUL) || last_char;
  assign status.end_char = end_char;
  assign is_digit        = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_space        = (char_byte == CH_SPACE) ||
                           ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
  assign digit           = char_byte[3:0];
  assign val_cur         = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  always_comb begin
    phase_next  = phase;
    stage_next  = stage;
    neg_next    = neg;
    acc_next    = acc;
    cnt_next    = cnt;
    yr_next     = yr;
    mo_next     = mo;
    dy_next     = dy;
    hr_next     = hr;
    mi_next     = mi;
    sc_next     = sc;
    failed_next = failed;
    done_next   = done;
    val_fin     = '0;
    ok_next     = 1'b0;

    if (cmd.take && (char_byte != CH_NUL) && !failed && !done) begin
      if ((stage == NS_START) && is_space) begin
        stage_next = stage;
      end else if ((stage == NS_START) &&
                   ((char_byte == CH_PLUS) || (char_byte == CH_MINUS))) begin
        neg_next   = (char_byte == CH_MINUS);
        stage_next = NS_SIGN;
      end else if (stage != NS_DIGITS) begin
        if (is_digit) begin
          stage_next = NS_DIGITS;
          acc_next   = 30'(digit);
          cnt_next   = 4'd1;
        end else begin
          failed_next = 1'b1;
        end
      end else if (is_digit) begin
        if (cnt >= 4'(MAX_DIGITS)) begin
          failed_next = 1'b1;
        end else begin
          acc_next = 30'((34'(acc) << 3) + (34'(acc) << 1) + 34'(digit));
          cnt_next = cnt + 4'd1;
        end
      end else begin
        // A non-digit closes the current number.
        case (phase)
          PH_YEAR:   yr_next = val_cur;
          PH_MONTH:  mo_next = val_cur;
          PH_DAY:    dy_next = val_cur;
          PH_HOUR:   hr_next = val_cur;
          PH_MINUTE: mi_next = val_cur;
          default:   sc_next = val_cur;
        endcase
        if (phase >= PH_SECOND) begin
          done_next = 1'b1;
        end else if (char_byte == sep_char(phase)) begin
          phase_next = phase + 3'd1;
          stage_next = NS_START;
          neg_next   = 1'b0;
          acc_next   = '0;
          cnt_next   = '0;
        end else begin
          failed_next = 1'b1;
        end
      end
    end

    // The text may end inside the seconds digits.
    if (cmd.take && end_char) begin
      val_fin = neg_next ? -$signed({1'b0, acc_next}) : $signed({1'b0, acc_next});
      if (!failed_next && !done_next && (phase_next == PH_SECOND) &&
          (stage_next == NS_DIGITS)) begin
        sc_next   = val_fin;
        done_next = 1'b1;
      end
      ok_next = done_next && !failed_next &&
                (mo_next >= 31'sd1) && (mo_next <= 31'sd12) &&
                (dy_next >= 31'sd1) && (dy_next <= 31'sd31);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      phase  <= PH_YEAR;
      stage  <= NS_START;
      neg    <= 1'b0;
      acc    <= '0;
      cnt    <= '0;
      yr     <= '0;
      mo     <= '0;
      dy     <= '0;
      hr     <= '0;
      mi     <= '0;
      sc     <= '0;
      failed <= 1'b0;
      done   <= 1'b0;
    end else begin
      phase  <= phase_next;
      stage  <= stage_next;
      neg    <= neg_next;
      acc    <= acc_next;
      cnt    <= cnt_next;
      yr     <= yr_next;
      mo     <= mo_next;
      dy     <= dy_next;
      hr     <= hr_next;
      mi     <= mi_next;
      sc     <= sc_next;
      failed <= failed_next;
      done   <= done_next;
    end
  end

  // Calendar arithmetic: the year is shifted to start in March, biased positive
  // and split into 400-year eras by a reciprocal multiplication.
  assign ys    = 34'(yr) - ((mo <= 31'sd2) ? 34'd1 : 34'd0);
  assign u_sum = ys + YEAR_BIAS;
  assign prod  = 60'(u_r[32:4]) * 60'(RECIP_25);
  assign qx400 = 33'(q_r) * 33'd400;
  assign cent  = (yoe_r >= 9'd300) ? 2'd3 :
                 (yoe_r >= 9'd200) ? 2'd2 :
                 (yoe_r >= 9'd100) ? 2'd1 : 2'd0;
  assign doy   = month_offset(mo[3:0]) + 9'(dy[4:0]) - 9'd1;
  assign phi   = 40'($signed(days_r[41:20])) * 40'sd86400;
  assign total = (60'(phi) << 20) + 60'(plo_r) + 60'(hms_r);

  always_ff @(posedge clk) begin
    if (cmd.take && end_char) begin
      calc_ok <= ok_next;
    end
    if (cmd.bias) begin
      u_r <= u_sum[32:0];
    end
    if (cmd.div) begin
      q_r <= prod[RECIP_SHIFT+23:RECIP_SHIFT];
    end
    if (cmd.rem) begin
      yoe_r <= 9'(u_r - qx400);
      era_r <= $signed(q_r - ERA_OFFSET);
    end
    if (cmd.doe) begin
      doe_r <= 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(cent) + 18'(doy);
      em_r  <= 42'(era_r) * 42'sd146097;
    end
    if (cmd.days) begin
      days_r <= em_r + $signed(42'(doe_r)) - 42'sd719468;
    end
    if (cmd.prod) begin
      plo_r <= 37'(days_r[19:0]) * 37'd86400;
      hms_r <= 44'(hr) * 44'sd3600 + 44'(mi) * 44'sd60 + 44'(sc);
    end
    if (cmd.load) begin
      epoch_seconds <= calc_ok ? $signed(total[56:0]) : '0;
      parse_ok      <= calc_ok;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/iso_datetime_to_epoch.sv =====
// Top level of the converter from ISO date-time text to signed Unix seconds.
//
//   Channel     Modport  Payload                          Moves per transfer
//   char_in     sink     char_byte[7:0], last_char        one text character
//   epoch_out   source   epoch_seconds[56:0], parse_ok    one converted timestamp
//
// Characters are taken at one per cycle while the text is being parsed.
// The byte that ends the text (a zero byte or one marked last_char) starts the
// conversion sequence of bias, division, remainder, day-of-era, days, product
// and sum steps in the shared calendar datapath; char_in is not ready meanwhile.
// A result waiting on epoch_out holds the final step, and with it char_in, until
// the sink takes it. Synchronous reset clears the parser and the output valid.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iso_datetime_to_epoch
  import idte_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input  logic clk,
  input  logic rst,
  idte_char_if.sink    char_in,
  idte_epoch_if.source epoch_out
);

  // Command and status between the controller and the datapath.
  idte_cmd_t    cmd;
  idte_status_t status;

  // The controller sequences parsing, the arithmetic steps and the output transfer.
  idte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (char_in.valid),
    .out_ready (epoch_out.ready),
    .status    (status),
    .in_ready  (char_in.ready),
    .out_valid (epoch_out.valid),
    .cmd       (cmd)
  );

  // The datapath holds the parsed fields, the arithmetic stages and the result.
  idte_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .char_byte     (char_in.char_byte),
    .last_char     (char_in.last_char),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (epoch_out.epoch_seconds),
    .parse_ok      (epoch_out.parse_ok)
  );

  // After the transfer that ends a text no further character is taken at once.
  `ASSERT_NEXT(a_end_holds_input, clk, rst, char_in.valid && char_in.ready && status.end_char, !char_in.ready)
  // A failed parse always reports zero seconds.
  `ASSERT_IMPLIES(a_fail_is_zero, clk, rst, epoch_out.valid && !epoch_out.parse_ok, epoch_out.epoch_seconds == '0)
  // A new result is loaded only when the output register is free.
  `ASSERT_IMPLIES(a_load_when_free, clk, rst, cmd.load, !epoch_out.valid || epoch_out.ready)
  // Characters are never taken while the conversion sequence runs.
  `ASSERT_IMPLIES(a_no_take_in_calc, clk, rst, cmd.bias || cmd.div || cmd.rem || cmd.doe, !char_in.ready)

endmodule

`default_nettype wire
